// ===== sv/voxel_neighbour_generator_macros.svh =====
`ifndef VOXEL_NEIGHBOUR_GENERATOR_MACROS_SVH
`define VOXEL_NEIGHBOUR_GENERATOR_MACROS_SVH

// Assertion helpers; every module that uses them has clk and arst_n.

// cond must never hold outside reset
`define VNG_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define VNG_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons in the following cycle
`define VNG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/vng_pkg.sv =====
package vng_pkg;

	localparam int NUM_OFS      = 26;
	localparam int NUM_FACES    = 6;
	localparam int SIZE_BITS    = 11;
	localparam int CFG_IDX_BITS = 2;
	localparam int OFS_IDX_BITS = $clog2(NUM_OFS);
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [SIZE_BITS-1:0] SIZE_RESET = 11'd1024;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SIZE_X     = 2'd0,
		CFG_SIZE_Y     = 2'd1,
		CFG_SIZE_Z     = 2'd2,
		CFG_FACES_ONLY = 2'd3
	} cfg_idx_t;

	// per-axis step: 2'b01 = +1, 2'b11 = -1, 2'b00 = stay
	typedef logic [1:0] step_t;

	localparam step_t STEP_ZERO = 2'b00;
	localparam step_t STEP_INC  = 2'b01;
	localparam step_t STEP_DEC  = 2'b11;

	typedef struct packed {
		step_t dx;
		step_t dy;
		step_t dz;
	} ofs_t;

	// faces, then edges, then corners
	localparam ofs_t OFS_TABLE [NUM_OFS] = '{
		'{STEP_INC,  STEP_ZERO, STEP_ZERO}, '{STEP_DEC,  STEP_ZERO, STEP_ZERO},
		'{STEP_ZERO, STEP_INC,  STEP_ZERO}, '{STEP_ZERO, STEP_DEC,  STEP_ZERO},
		'{STEP_ZERO, STEP_ZERO, STEP_INC }, '{STEP_ZERO, STEP_ZERO, STEP_DEC },
		'{STEP_INC,  STEP_INC,  STEP_ZERO}, '{STEP_DEC,  STEP_INC,  STEP_ZERO},
		'{STEP_INC,  STEP_DEC,  STEP_ZERO}, '{STEP_DEC,  STEP_DEC,  STEP_ZERO},
		'{STEP_ZERO, STEP_INC,  STEP_INC }, '{STEP_ZERO, STEP_INC,  STEP_DEC },
		'{STEP_ZERO, STEP_DEC,  STEP_INC }, '{STEP_ZERO, STEP_DEC,  STEP_DEC },
		'{STEP_INC,  STEP_ZERO, STEP_INC }, '{STEP_INC,  STEP_ZERO, STEP_DEC },
		'{STEP_DEC,  STEP_ZERO, STEP_INC }, '{STEP_DEC,  STEP_ZERO, STEP_DEC },
		'{STEP_INC,  STEP_INC,  STEP_INC }, '{STEP_DEC,  STEP_DEC,  STEP_DEC },
		'{STEP_INC,  STEP_INC,  STEP_DEC }, '{STEP_INC,  STEP_DEC,  STEP_INC },
		'{STEP_DEC,  STEP_INC,  STEP_INC }, '{STEP_INC,  STEP_DEC,  STEP_DEC },
		'{STEP_DEC,  STEP_DEC,  STEP_INC }, '{STEP_DEC,  STEP_INC,  STEP_DEC }
	};

	// which moves along one axis stay inside the grid
	typedef struct packed {
		logic dec_ok;
		logic stay_ok;
		logic inc_ok;
	} axis_ok_t;

endpackage

// ===== sv/vng_voxel_if.sv =====
interface vng_voxel_if #(
	parameter int COORD_BITS = 10
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] voxel_x;
	logic [COORD_BITS-1:0] voxel_y;
	logic [COORD_BITS-1:0] voxel_z;

	modport source (output valid, voxel_x, voxel_y, voxel_z, input ready);
	modport sink   (input valid, voxel_x, voxel_y, voxel_z, output ready);
endinterface

// ===== sv/vng_neighbour_if.sv =====
interface vng_neighbour_if #(
	parameter int COORD_BITS = 10
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] neighbour_x;
	logic [COORD_BITS-1:0] neighbour_y;
	logic [COORD_BITS-1:0] neighbour_z;
	logic                  last_neighbour;

	modport source (output valid, neighbour_x, neighbour_y, neighbour_z, last_neighbour,
		input ready);
	modport sink   (input valid, neighbour_x, neighbour_y, neighbour_z, last_neighbour,
		output ready);
endinterface

// ===== sv/vng_front.sv =====
module vng_front #(
	parameter int COORD_BITS = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [vng_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [vng_pkg::SIZE_BITS-1:0]          cfg_data,
	vng_voxel_if.sink                              vox_in,
	input  logic                                   q_full,
	output logic                                   push,
	output logic [COORD_BITS-1:0]                  push_x,
	output logic [COORD_BITS-1:0]                  push_y,
	output logic [COORD_BITS-1:0]                  push_z,
	output logic [vng_pkg::NUM_OFS-1:0]            push_mask
);

	localparam int CMP_W = (COORD_BITS + 1 > vng_pkg::SIZE_BITS) ?
		COORD_BITS + 1 : vng_pkg::SIZE_BITS;

	logic [vng_pkg::SIZE_BITS-1:0] size_x_q;
	logic [vng_pkg::SIZE_BITS-1:0] size_y_q;
	logic [vng_pkg::SIZE_BITS-1:0] size_z_q;
	logic                          faces_only_q;

	vng_pkg::axis_ok_t ok_x;
	vng_pkg::axis_ok_t ok_y;
	vng_pkg::axis_ok_t ok_z;

	function automatic vng_pkg::axis_ok_t classify(
		input logic [COORD_BITS-1:0]         c,
		input logic [vng_pkg::SIZE_BITS-1:0] size
	);
		logic [CMP_W-1:0]  cw;
		logic [CMP_W-1:0]  sw;
		vng_pkg::axis_ok_t r;
		cw = CMP_W'(c);
		sw = CMP_W'(size);
		r.stay_ok = cw < sw;
		// c-1 < size  <=>  c <= size
		r.dec_ok  = (c != '0) && (cw <= sw);
		// c+1 must also fit the coordinate field
		r.inc_ok  = (c != '1) && ((cw + CMP_W'(1)) < sw);
		return r;
	endfunction

	function automatic logic pick(input vng_pkg::axis_ok_t a, input vng_pkg::step_t d);
		logic r;
		case (d)
			vng_pkg::STEP_INC: r = a.inc_ok;
			vng_pkg::STEP_DEC: r = a.dec_ok;
			default:           r = a.stay_ok;
		endcase
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q     <= vng_pkg::SIZE_RESET;
			size_y_q     <= vng_pkg::SIZE_RESET;
			size_z_q     <= vng_pkg::SIZE_RESET;
			faces_only_q <= 1'b0;
		end else if (cfg_we) begin
			case (vng_pkg::cfg_idx_t'(cfg_index))
				vng_pkg::CFG_SIZE_X:     size_x_q     <= cfg_data;
				vng_pkg::CFG_SIZE_Y:     size_y_q     <= cfg_data;
				vng_pkg::CFG_SIZE_Z:     size_z_q     <= cfg_data;
				vng_pkg::CFG_FACES_ONLY: faces_only_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign ok_x = classify(vox_in.voxel_x, size_x_q);
	assign ok_y = classify(vox_in.voxel_y, size_y_q);
	assign ok_z = classify(vox_in.voxel_z, size_z_q);

	always_comb begin
		for (int n = 0; n < vng_pkg::NUM_OFS; n++) begin
			push_mask[n] = pick(ok_x, vng_pkg::OFS_TABLE[n].dx) &&
				pick(ok_y, vng_pkg::OFS_TABLE[n].dy) &&
				pick(ok_z, vng_pkg::OFS_TABLE[n].dz) &&
				(!faces_only_q || (n < vng_pkg::NUM_FACES));
		end
	end

	assign vox_in.ready = !q_full;
	assign push         = vox_in.valid && !q_full;
	assign push_x       = vox_in.voxel_x;
	assign push_y       = vox_in.voxel_y;
	assign push_z       = vox_in.voxel_z;

endmodule

// ===== sv/vng_queue.sv =====
module vng_queue #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= bump(wr_ptr_q);
			if (pop)
				rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			store_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== sv/vng_back.sv =====
`include "voxel_neighbour_generator_macros.svh"

module vng_back #(
	parameter int COORD_BITS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  logic [COORD_BITS-1:0]       q_x,
	input  logic [COORD_BITS-1:0]       q_y,
	input  logic [COORD_BITS-1:0]       q_z,
	input  logic [vng_pkg::NUM_OFS-1:0] q_mask,
	output logic                        q_pop,
	vng_neighbour_if.source             nbr_out
);

	logic                          cur_valid_q;
	logic [COORD_BITS-1:0]         cur_x_q;
	logic [COORD_BITS-1:0]         cur_y_q;
	logic [COORD_BITS-1:0]         cur_z_q;
	logic [vng_pkg::NUM_OFS-1:0]   rem_q;

	logic                          out_valid_q;
	logic [COORD_BITS-1:0]         out_x_q;
	logic [COORD_BITS-1:0]         out_y_q;
	logic [COORD_BITS-1:0]         out_z_q;
	logic                          out_last_q;

	logic                          out_adv;
	logic                          emit;
	logic                          finish;
	logic [vng_pkg::NUM_OFS-1:0]   sel;
	logic [vng_pkg::NUM_OFS-1:0]   rest;
	logic [vng_pkg::OFS_IDX_BITS-1:0] sel_idx;
	vng_pkg::ofs_t                 ofs;

	function automatic logic [COORD_BITS-1:0] step_coord(
		input logic [COORD_BITS-1:0] c,
		input vng_pkg::step_t        d
	);
		logic [COORD_BITS-1:0] r;
		case (d)
			vng_pkg::STEP_INC: r = c + COORD_BITS'(1);
			vng_pkg::STEP_DEC: r = c - COORD_BITS'(1);
			default:           r = c;
		endcase
		return r;
	endfunction

	// lowest pending offset goes out next
	assign sel  = rem_q & (~rem_q + vng_pkg::NUM_OFS'(1));
	assign rest = rem_q & ~sel;

	always_comb begin
		sel_idx = '0;
		for (int i = vng_pkg::NUM_OFS - 1; i >= 0; i--) begin
			if (rem_q[i])
				sel_idx = vng_pkg::OFS_IDX_BITS'(i);
		end
	end

	assign ofs     = vng_pkg::OFS_TABLE[sel_idx];
	assign out_adv = !out_valid_q || nbr_out.ready;
	assign emit    = cur_valid_q && out_adv;
	assign finish  = emit && (rest == '0);
	// items with no neighbour are dropped on load
	assign q_pop   = !q_empty && (!cur_valid_q || finish);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop)
				cur_valid_q <= q_mask != '0;
			else if (finish)
				cur_valid_q <= 1'b0;
			if (out_adv)
				out_valid_q <= cur_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_x_q <= q_x;
			cur_y_q <= q_y;
			cur_z_q <= q_z;
			rem_q   <= q_mask;
		end else if (emit) begin
			rem_q   <= rest;
		end
		if (emit) begin
			out_x_q    <= step_coord(cur_x_q, ofs.dx);
			out_y_q    <= step_coord(cur_y_q, ofs.dy);
			out_z_q    <= step_coord(cur_z_q, ofs.dz);
			out_last_q <= rest == '0;
		end
	end

	assign nbr_out.valid          = out_valid_q;
	assign nbr_out.neighbour_x    = out_x_q;
	assign nbr_out.neighbour_y    = out_y_q;
	assign nbr_out.neighbour_z    = out_z_q;
	assign nbr_out.last_neighbour = out_last_q;

	`VNG_ASSERT_NEVER(a_cur_has_work, cur_valid_q && (rem_q == '0), "active item with no neighbour left")
	`VNG_ASSERT_NEVER(a_pop_nonempty, q_pop && q_empty, "pop from empty queue")
	`VNG_ASSERT_IMPL(a_sel_single, cur_valid_q, $onehot(sel), "selection not one-hot")
	`VNG_ASSERT_NEXT(a_item_continues, emit && (rest != '0), cur_valid_q, "item dropped early")

endmodule

// ===== sv/voxel_neighbour_generator.sv =====
// Channel   Direction  Carries
// vox_in    in         voxel_x, voxel_y, voxel_z (centre voxel)
// nbr_out   out        neighbour_x/y/z, last_neighbour (one in-grid neighbour per beat)
// cfg_*     in         grid_size_x/y/z, faces_only (write only)
//
// An input beat is accepted whenever the two-entry queue has room.
// The back end emits one neighbour per cycle unless nbr_out stalls: an item with
// k in-grid neighbours gives k beats, an item with none is dropped (nothing emitted).
// Results pass through an output register; a stalled nbr_out holds it and the
// queue fills, then vox_in.ready drops. Reset is asynchronous, active low.
module voxel_neighbour_generator #(
	parameter int COORD_BITS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vng_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [vng_pkg::SIZE_BITS-1:0]     cfg_data,
	vng_voxel_if.sink                         vox_in,
	vng_neighbour_if.source                   nbr_out
);

	localparam int ENTRY_W = 3 * COORD_BITS + vng_pkg::NUM_OFS;

	logic                        push;
	logic [COORD_BITS-1:0]       push_x;
	logic [COORD_BITS-1:0]       push_y;
	logic [COORD_BITS-1:0]       push_z;
	logic [vng_pkg::NUM_OFS-1:0] push_mask;
	logic                        q_full;
	logic                        q_empty;
	logic                        q_pop;
	logic [ENTRY_W-1:0]          q_data;
	logic [COORD_BITS-1:0]       q_x;
	logic [COORD_BITS-1:0]       q_y;
	logic [COORD_BITS-1:0]       q_z;
	logic [vng_pkg::NUM_OFS-1:0] q_mask;

	vng_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.vox_in    (vox_in),
		.q_full    (q_full),
		.push      (push),
		.push_x    (push_x),
		.push_y    (push_y),
		.push_z    (push_z),
		.push_mask (push_mask)
	);

	vng_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(vng_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_x, push_y, push_z, push_mask}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	assign {q_x, q_y, q_z, q_mask} = q_data;

	vng_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_x     (q_x),
		.q_y     (q_y),
		.q_z     (q_z),
		.q_mask  (q_mask),
		.q_pop   (q_pop),
		.nbr_out (nbr_out)
	);

endmodule
